// ===== rtl/kcbs_pkg.sv =====
// Shared types and constants of the strand-symmetric k-mer counter.
package kcbs_pkg;

    localparam int OP_W    = 2;
    localparam int BASE_W  = 2;
    localparam int IDX_W   = 12;
    localparam int ORDER_W = 3;
    localparam int FILL_W  = 3;
    localparam int TOTAL_W = 32;

    localparam logic [OP_W-1:0] OP_FEED  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd5;

    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;

    typedef enum logic [1:0] {
        CMD_BUMP,
        CMD_READ,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [TOTAL_W-1:0]   gc_total;
        logic [TOTAL_W-1:0]   base_total;
    } t_cmd_hdr;

endpackage

// ===== rtl/kcbs_fifo.sv =====
// Small register queue between the request front end and the table engine.
module kcbs_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_not_empty,
    output logic              o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/kcbs_front.sv =====
// Front end: takes requests, keeps rolling windows and base totals, queues table commands.
module kcbs_front import kcbs_pkg::*; #(
    parameter int MAX_ORDER = 5,
    parameter int ADDR_W    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [BASE_W-1:0]  i_base,
    input  logic               i_last_base,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ORDER_W-1:0] i_cfg_model_order,
    input  logic               i_space,
    output logic               o_push,
    output t_cmd_hdr           o_hdr,
    output logic [ADDR_W-1:0]  o_addr_a,
    output logic [ADDR_W-1:0]  o_addr_b
);

    localparam int DIG = ADDR_W / 2;
    localparam int K_W = ORDER_W + 1;

    logic [ORDER_W-1:0] r_order;
    logic [FILL_W-1:0]  r_fill;
    logic [ADDR_W-1:0]  r_fw;
    logic [ADDR_W-1:0]  r_rc;
    logic [TOTAL_W-1:0] r_gc_total;
    logic [TOTAL_W-1:0] r_base_total;

    logic [ORDER_W-1:0] ord;
    logic [K_W-1:0]     k;
    logic [ADDR_W-1:0]  fw_sh;
    logic [ADDR_W-1:0]  rc_sh;
    logic [ADDR_W-1:0]  n_fw;
    logic [ADDR_W-1:0]  n_rc;
    logic               accept;
    logic               window_full;
    logic               is_gc;

    assign o_ready     = i_space;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign window_full = (r_fill >= ord);
    assign is_gc       = (i_base == BASE_C) || (i_base == BASE_G);

    always_comb begin
        ord = r_order;
        if (ord == '0) begin
            ord = ORDER_W'(1);
        end
        if (ord > ORDER_W'(MAX_ORDER)) begin
            ord = ORDER_W'(MAX_ORDER);
        end
        k     = K_W'(ord) + 1'b1;
        fw_sh = {r_fw[ADDR_W-3:0], i_base};
        rc_sh = {2'b00, r_rc[ADDR_W-1:2]};
        for (int j = 0; j < DIG; j++) begin
            if (K_W'(j) < k) begin
                n_fw[2*j +: 2] = fw_sh[2*j +: 2];
                n_rc[2*j +: 2] = (K_W'(j) == k - 1'b1) ? ~i_base : rc_sh[2*j +: 2];
            end else begin
                n_fw[2*j +: 2] = 2'b00;
                n_rc[2*j +: 2] = 2'b00;
            end
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_hdr.kind       = CMD_BUMP;
        o_hdr.gc_total   = r_gc_total;
        o_hdr.base_total = r_base_total;
        o_addr_a = ADDR_W'(i_entry_index);
        o_addr_b = n_rc;
        unique case (i_operation)
            OP_FEED: begin
                o_push   = accept && window_full;
                o_addr_a = n_fw;
            end
            OP_READ: begin
                o_push     = accept;
                o_hdr.kind = CMD_READ;
            end
            OP_CLEAR: begin
                o_push     = accept;
                o_hdr.kind = CMD_CLEAR;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order      <= ORDER_RESET;
            r_fill       <= '0;
            r_fw         <= '0;
            r_rc         <= '0;
            r_gc_total   <= '0;
            r_base_total <= '0;
        end else begin
            if (accept && i_operation == OP_FEED) begin
                r_fw <= n_fw;
                r_rc <= n_rc;
                if (r_base_total != '1) begin
                    r_base_total <= r_base_total + 1'b1;
                end
                if (is_gc && r_gc_total != '1) begin
                    r_gc_total <= r_gc_total + 1'b1;
                end
                if (i_last_base) begin
                    r_fill <= '0;
                end else if (!window_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_model_order;
                r_fill  <= '0;
            end
        end
    end

endmodule

// ===== rtl/kcbs_back.sv =====
// Table engine: counter memory with read-modify-write pipeline, clear sweep and result register.
module kcbs_back import kcbs_pkg::*; #(
    parameter int ADDR_W     = 12,
    parameter int COUNT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  t_cmd_hdr           i_hdr,
    input  logic [ADDR_W-1:0]  i_addr_a,
    input  logic [ADDR_W-1:0]  i_addr_b,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TOTAL_W-1:0] o_entry_count,
    output logic [TOTAL_W-1:0] o_gc_total,
    output logic [TOTAL_W-1:0] o_base_total
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  r_clr_busy;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic                  r_half;

    logic                  r_s1_valid;
    t_cmd_hdr              r_s1_hdr;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s1_byp;
    logic [COUNT_BITS-1:0] r_s1_byp_data;

    logic                  r_out_valid;
    logic [TOTAL_W-1:0]    r_out_count;
    logic [TOTAL_W-1:0]    r_out_gc;
    logic [TOTAL_W-1:0]    r_out_base;

    logic                  adv;
    logic                  issue;
    logic [ADDR_W-1:0]     iss_addr;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;
    logic [TOTAL_W-1:0]    cur_sat;

    assign adv = !(r_s1_valid && r_s1_hdr.kind == CMD_READ && r_out_valid && !i_ready);
    assign issue     = !r_clr_busy && i_cmd_valid && adv;
    assign iss_addr  = r_half ? i_addr_b : i_addr_a;
    assign o_cmd_pop = issue && (i_hdr.kind != CMD_BUMP || r_half);
    assign o_busy    = r_clr_busy;

    assign cur   = r_s1_byp ? r_s1_byp_data : r_rd_data;
    assign wr_en = r_s1_valid && adv && r_s1_hdr.kind != CMD_READ;

    always_comb begin
        wr_data = '0;
        if (r_s1_hdr.kind == CMD_BUMP) begin
            wr_data = (cur == '1) ? cur : cur + 1'b1;
        end
    end

    generate
        if (COUNT_BITS > TOTAL_W) begin : g_sat
            assign cur_sat = (|cur[COUNT_BITS-1:TOTAL_W]) ? '1 : cur[TOTAL_W-1:0];
        end else begin : g_ext
            assign cur_sat = TOTAL_W'(cur);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[iss_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_hdr      <= i_hdr;
            r_s1_addr     <= iss_addr;
            r_s1_byp      <= wr_en && (r_s1_addr == iss_addr);
            r_s1_byp_data <= wr_data;
        end
        if (r_s1_valid && r_s1_hdr.kind == CMD_READ && adv) begin
            r_out_count <= cur_sat;
            r_out_gc    <= r_s1_hdr.gc_total;
            r_out_base  <= r_s1_hdr.base_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_half      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (issue && i_hdr.kind == CMD_BUMP) begin
                r_half <= !r_half;
            end
            if (adv) begin
                r_s1_valid <= issue;
            end
            if (r_s1_valid && r_s1_hdr.kind == CMD_READ && adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_count = r_out_count;
    assign o_gc_total    = r_out_gc;
    assign o_base_total  = r_out_base;

endmodule

// ===== rtl/kmer_count_both_strands.sv =====
// Top level of the strand-symmetric k-mer counter.
//
//  channel   signals                                   direction
//  request   i_valid/o_ready, operation, base, ...     in
//  result    o_valid/i_ready, entry_count, totals      out
//  config    i_cfg_valid/o_cfg_ready, model_order      in
//
// Front end takes one request per cycle while the 4-entry queue has room and no clearing sweep runs.
// A counted base takes two counter updates in the table engine (through one memory
// read port and one write port); read and clear take one table access each.
// A read request passes through the queue, the stage-1 register and the result register before its result is valid.
// After reset a clearing sweep over all 2^(2*MAX_ORDER+2) counter entries (4096) holds o_ready low.
// A stalled result stalls the engine; the queue then fills and stalls requests.
module kmer_count_both_strands import kcbs_pkg::*; #(
    parameter int MAX_ORDER  = 5,
    parameter int COUNT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [BASE_W-1:0]  i_base,
    input  logic               i_last_base,
    input  logic [IDX_W-1:0]   i_entry_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TOTAL_W-1:0] o_entry_count,
    output logic [TOTAL_W-1:0] o_gc_total,
    output logic [TOTAL_W-1:0] o_base_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ORDER_W-1:0] i_cfg_model_order
);

    localparam int ADDR_W  = 2 * MAX_ORDER + 2;
    localparam int HDR_W   = $bits(t_cmd_hdr);
    localparam int ENTRY_W = HDR_W + 2 * ADDR_W;
    localparam int QDEPTH  = 4;

    logic              push;
    t_cmd_hdr          push_hdr;
    logic [ADDR_W-1:0] push_addr_a;
    logic [ADDR_W-1:0] push_addr_b;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic [ENTRY_W-1:0] q_data;
    logic              busy;
    t_cmd_hdr          head_hdr;
    logic [ADDR_W-1:0] head_addr_a;
    logic [ADDR_W-1:0] head_addr_b;

    assign {head_hdr, head_addr_a, head_addr_b} = q_data;

    kcbs_front #(
        .MAX_ORDER (MAX_ORDER),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_base            (i_base),
        .i_last_base       (i_last_base),
        .i_entry_index     (i_entry_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_model_order (i_cfg_model_order),
        .i_space           (!q_full && !busy),
        .o_push            (push),
        .o_hdr             (push_hdr),
        .o_addr_a          (push_addr_a),
        .o_addr_b          (push_addr_b)
    );

    kcbs_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      ({push_hdr, push_addr_a, push_addr_b}),
        .i_pop       (q_pop),
        .o_data      (q_data),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    kcbs_back #(
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_not_empty),
        .o_cmd_pop     (q_pop),
        .i_hdr         (head_hdr),
        .i_addr_a      (head_addr_a),
        .i_addr_b      (head_addr_b),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_count (o_entry_count),
        .o_gc_total    (o_gc_total),
        .o_base_total  (o_base_total)
    );

endmodule
